// ===== rtl/lrs_pkg.sv =====
// Shared types and constants for the lineage recombination split block.
`timescale 1ns / 1ps
package lrs_pkg;

  localparam int LOCUS_W   = 6;
  localparam int RATE_IN_W = 24;
  localparam int DRAW_W    = 24;
  localparam int MASK_W    = 64;
  localparam int TOTAL_W   = 30;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 30'h3FFF_FFFF;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SPLIT = 1'b1;

  typedef logic [1:0] arith_op_t;

  localparam arith_op_t OP_SUM  = 2'd0;
  localparam arith_op_t OP_MUL  = 2'd1;
  localparam arith_op_t OP_SRCH = 2'd2;

  typedef struct packed {
    arith_op_t op;
    logic      mul_bit;
  } arith_ctl_t;

endpackage

// ===== rtl/lrs_if.sv =====
// Request and result channel interfaces for the lineage recombination split block.
`timescale 1ns / 1ps
interface lrs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [lrs_pkg::LOCUS_W-1:0]   locus_index;
  logic [lrs_pkg::RATE_IN_W-1:0] rate_value;
  logic [lrs_pkg::LOCUS_W-1:0]   first_locus;
  logic [lrs_pkg::LOCUS_W-1:0]   last_locus;
  logic [lrs_pkg::MASK_W-1:0]    ancestral_mask;
  logic [lrs_pkg::DRAW_W-1:0]    draw_occur;
  logic [lrs_pkg::DRAW_W-1:0]    draw_position;

  modport source (
    output valid, func, locus_index, rate_value, first_locus, last_locus,
           ancestral_mask, draw_occur, draw_position,
    input  ready
  );
  modport sink (
    input  valid, func, locus_index, rate_value, first_locus, last_locus,
           ancestral_mask, draw_occur, draw_position,
    output ready
  );
endinterface

interface lrs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       recombined;
  logic [lrs_pkg::TOTAL_W-1:0] total_rate;
  logic [lrs_pkg::LOCUS_W-1:0] break_locus;
  logic [lrs_pkg::MASK_W-1:0]  left_mask;
  logic [lrs_pkg::LOCUS_W-1:0] left_last;
  logic [lrs_pkg::MASK_W-1:0]  right_mask;
  logic [lrs_pkg::LOCUS_W-1:0] right_first;

  modport source (
    output valid, recombined, total_rate, break_locus, left_mask, left_last,
           right_mask, right_first,
    input  ready
  );
  modport sink (
    input  valid, recombined, total_rate, break_locus, left_mask, left_last,
           right_mask, right_first,
    output ready
  );
endinterface

// ===== rtl/lrs_rate_mem.sv =====
// Per-locus rate table with per-entry valid bits and registered read.
`timescale 1ns / 1ps
module lrs_rate_mem #(
  parameter int NUM_LOCI  = 64,
  parameter int RATE_BITS = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [lrs_pkg::LOCUS_W-1:0] waddr_i,
  input  logic [RATE_BITS-1:0]        wdata_i,
  input  logic [lrs_pkg::LOCUS_W-1:0] raddr_i,
  output logic [RATE_BITS-1:0]        rdata_o
);

  localparam int AW = (NUM_LOCI > 1) ? $clog2(NUM_LOCI) : 1;

  logic [RATE_BITS-1:0] mem [NUM_LOCI];
  logic [NUM_LOCI-1:0]  valid_q;
  logic [RATE_BITS-1:0] rdata_q;
  logic                 w_in_range;
  logic                 r_in_range;

  assign w_in_range = ({1'b0, waddr_i} < (lrs_pkg::LOCUS_W + 1)'(NUM_LOCI));
  assign r_in_range = ({1'b0, raddr_i} < (lrs_pkg::LOCUS_W + 1)'(NUM_LOCI));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i && w_in_range) begin
      valid_q[waddr_i[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i && w_in_range) begin
      mem[waddr_i[AW-1:0]] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_in_range && valid_q[raddr_i[AW-1:0]]) begin
      rdata_q <= mem[raddr_i[AW-1:0]];
    end else begin
      rdata_q <= '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lrs_arith.sv =====
// Shared adder and break compare used by the sum, multiply and search passes.
`timescale 1ns / 1ps
module lrs_arith #(
  parameter int RATE_BITS = 24
) (
  input  lrs_pkg::arith_ctl_t                               ctl_i,
  input  logic [RATE_BITS+lrs_pkg::LOCUS_W+lrs_pkg::DRAW_W-1:0] acc_i,
  input  logic [RATE_BITS+lrs_pkg::LOCUS_W+lrs_pkg::DRAW_W-1:0] mcand_i,
  input  logic [RATE_BITS+lrs_pkg::LOCUS_W+lrs_pkg::DRAW_W-1:0] prod_i,
  input  logic [RATE_BITS-1:0]                              rate_i,
  output logic [RATE_BITS+lrs_pkg::LOCUS_W+lrs_pkg::DRAW_W-1:0] sum_o,
  output logic                                              hit_o
);

  localparam int TW = RATE_BITS + lrs_pkg::LOCUS_W;
  localparam int PW = TW + lrs_pkg::DRAW_W;

  logic [PW-1:0] addend;
  logic [PW-1:0] scaled;

  always_comb begin
    case (ctl_i.op)
      lrs_pkg::OP_SUM:  addend = PW'(rate_i);
      lrs_pkg::OP_MUL:  addend = ctl_i.mul_bit ? mcand_i : '0;
      lrs_pkg::OP_SRCH: addend = PW'(rate_i);
      default:          addend = '0;
    endcase
  end

  assign sum_o  = acc_i + addend;
  // running sum scaled by 2^24 against draw_position * total
  assign scaled = {sum_o[TW-1:0], {lrs_pkg::DRAW_W{1'b0}}};
  assign hit_o  = (scaled >= prod_i);

endmodule

// ===== rtl/lineage_recombination_split_core.sv =====
// Lineage recombination split: top level with pass sequencer and result register.
// Steps: a rate write goes straight to the load; a lineage runs a sum pass, a decide step and,
//   on recombination, a multiply pass, a break search and a right_first scan, then a load.
// Flow: one transaction at a time; a lineage's pace is set by the one-per-cycle rate table
//   read and the one shared adder.
// Reset: control state and the rate table valid bits clear at once; no sweep.
`timescale 1ns / 1ps
module lineage_recombination_split_core #(
  parameter int NUM_LOCI  = 64,
  parameter int RATE_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrs_in_if.sink    req_i,
  lrs_out_if.source rsp_o
);

  localparam int LW = lrs_pkg::LOCUS_W;
  localparam int MW = lrs_pkg::MASK_W;
  localparam int TW = RATE_BITS + LW;
  localparam int PW = TW + lrs_pkg::DRAW_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_OCC   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SRCH  = 3'd4;
  localparam logic [2:0] S_RSCAN = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]               state_q, state_d;
  logic [LW-1:0]            idx_q, idx_d;
  logic                     rd_v_q, rd_v_d;
  logic [LW-1:0]            rd_idx_q;
  logic [LW-1:0]            first_q, first_d;
  logic [LW-1:0]            last_q, last_d;
  logic [MW-1:0]            amask_q, amask_d;
  logic [lrs_pkg::DRAW_W-1:0] docc_q, docc_d;
  logic [lrs_pkg::DRAW_W-1:0] mplier_q, mplier_d;
  logic [TW-1:0]            total_q, total_d;
  logic [TW-1:0]            run_q, run_d;
  logic [PW-1:0]            prod_q, prod_d;
  logic [PW-1:0]            mcand_q, mcand_d;
  logic [LW-1:0]            brk_q, brk_d;
  logic [LW-1:0]            llast_q, llast_d;
  logic [LW-1:0]            rfirst_q, rfirst_d;
  logic                     recomb_q, recomb_d;

  logic                     out_valid_q, out_valid_d;
  logic                     out_recomb_q;
  logic [lrs_pkg::TOTAL_W-1:0] out_total_q;
  logic [LW-1:0]            out_brk_q;
  logic [MW-1:0]            out_lmask_q;
  logic [LW-1:0]            out_llast_q;
  logic [MW-1:0]            out_rmask_q;
  logic [LW-1:0]            out_rfirst_q;
  logic                     out_load;

  logic                     in_fire;
  logic                     mem_we;
  logic [RATE_BITS-1:0]     rate_rd;
  lrs_pkg::arith_ctl_t      actl;
  logic [PW-1:0]            acc;
  logic [PW-1:0]            sum;
  logic                     hit;
  logic [MW-1:0]            low_mask;
  logic [lrs_pkg::TOTAL_W-1:0] total_sat;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign mem_we      = in_fire && (req_i.func == lrs_pkg::FUNC_WRITE);

  lrs_rate_mem #(
    .NUM_LOCI (NUM_LOCI),
    .RATE_BITS(RATE_BITS)
  ) u_rate_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(req_i.locus_index),
    .wdata_i(RATE_BITS'(req_i.rate_value)),
    .raddr_i(idx_q),
    .rdata_o(rate_rd)
  );

  always_comb begin
    actl.mul_bit = mplier_q[0];
    case (state_q)
      S_MUL:   begin
        actl.op = lrs_pkg::OP_MUL;
        acc     = prod_q;
      end
      S_SRCH:  begin
        actl.op = lrs_pkg::OP_SRCH;
        acc     = PW'(run_q);
      end
      default: begin
        actl.op = lrs_pkg::OP_SUM;
        acc     = PW'(total_q);
      end
    endcase
  end

  lrs_arith #(
    .RATE_BITS(RATE_BITS)
  ) u_arith (
    .ctl_i  (actl),
    .acc_i  (acc),
    .mcand_i(mcand_q),
    .prod_i (prod_q),
    .rate_i (rate_rd),
    .sum_o  (sum),
    .hit_o  (hit)
  );

  always_comb begin
    for (int k = 0; k < MW; k++) begin
      low_mask[k] = (k <= int'(brk_q));
    end
  end

  assign total_sat = (64'(total_q) > 64'(lrs_pkg::TOTAL_MAX)) ? lrs_pkg::TOTAL_MAX
                                                             : lrs_pkg::TOTAL_W'(total_q);

  assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    rd_v_d   = 1'b0;
    first_d  = first_q;
    last_d   = last_q;
    amask_d  = amask_q;
    docc_d   = docc_q;
    mplier_d = mplier_q;
    total_d  = total_q;
    run_d    = run_q;
    prod_d   = prod_q;
    mcand_d  = mcand_q;
    brk_d    = brk_q;
    llast_d  = llast_q;
    rfirst_d = rfirst_q;
    recomb_d = recomb_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          total_d  = '0;
          recomb_d = 1'b0;
          if (req_i.func == lrs_pkg::FUNC_WRITE) begin
            state_d = S_FIN;
          end else begin
            first_d = req_i.first_locus;
            last_d  = req_i.last_locus;
            idx_d   = req_i.first_locus;
            docc_d  = req_i.draw_occur;
            mplier_d = req_i.draw_position;
            for (int k = 0; k < MW; k++) begin
              amask_d[k] = req_i.ancestral_mask[k] && (k < NUM_LOCI);
            end
            state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (idx_q < last_q) begin
          idx_d  = idx_q + LW'(1);
          rd_v_d = 1'b1;
        end
        if (rd_v_q) begin
          total_d = sum[TW-1:0];
        end
        if (!(idx_q < last_q) && !rd_v_q) begin
          state_d = S_OCC;
        end
      end
      S_OCC: begin
        mcand_d = PW'(total_q);
        prod_d  = '0;
        if (PW'(docc_q) < PW'(total_q)) begin
          recomb_d = 1'b1;
          state_d  = S_MUL;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MUL: begin
        if (mplier_q == '0) begin
          idx_d   = first_q;
          run_d   = '0;
          llast_d = first_q;
          state_d = S_SRCH;
        end else begin
          prod_d   = sum;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      S_SRCH: begin
        if (idx_q < last_q) begin
          idx_d  = idx_q + LW'(1);
          rd_v_d = 1'b1;
        end
        if (rd_v_q) begin
          run_d = sum[TW-1:0];
          if (amask_q[rd_idx_q]) begin
            llast_d = rd_idx_q;
          end
          if (hit) begin
            brk_d   = rd_idx_q;
            idx_d   = rd_idx_q + LW'(1);
            rd_v_d  = 1'b0;
            state_d = S_RSCAN;
          end
        end
      end
      S_RSCAN: begin
        if (amask_q[idx_q] || (idx_q == last_q)) begin
          rfirst_d = idx_q;
          state_d  = S_FIN;
        end else begin
          idx_d = idx_q + LW'(1);
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    rd_idx_q <= idx_q;
    first_q  <= first_d;
    last_q   <= last_d;
    amask_q  <= amask_d;
    docc_q   <= docc_d;
    mplier_q <= mplier_d;
    total_q  <= total_d;
    run_q    <= run_d;
    prod_q   <= prod_d;
    mcand_q  <= mcand_d;
    brk_q    <= brk_d;
    llast_q  <= llast_d;
    rfirst_q <= rfirst_d;
    recomb_q <= recomb_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_recomb_q <= recomb_q;
      out_total_q  <= total_sat;
      out_brk_q    <= recomb_q ? brk_q : '0;
      out_lmask_q  <= recomb_q ? (amask_q & low_mask) : '0;
      out_llast_q  <= recomb_q ? llast_q : '0;
      out_rmask_q  <= recomb_q ? (amask_q & ~low_mask) : '0;
      out_rfirst_q <= recomb_q ? rfirst_q : '0;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.recombined  = out_recomb_q;
  assign rsp_o.total_rate  = out_total_q;
  assign rsp_o.break_locus = out_brk_q;
  assign rsp_o.left_mask   = out_lmask_q;
  assign rsp_o.left_last   = out_llast_q;
  assign rsp_o.right_mask  = out_rmask_q;
  assign rsp_o.right_first = out_rfirst_q;

endmodule
